### rtl/imms_pkg.sv
// ----------------------------------------------------------------------------
// imms_pkg
// Shared constants for the frame min/max statistics block: register indexes,
// report codes, field widths and reset values.
// ----------------------------------------------------------------------------
package imms_pkg;

  // Frame size limit and configuration port widths
  localparam int DEFAULT_MAX_DIM = 4096;
  localparam int CFG_W           = 13;
  localparam int CFG_IDX_W       = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  // Pixel and report field widths
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 3 * CHAN_W;
  localparam int SUM_W   = 10;
  localparam int COORD_W = 12;
  localparam int KIND_W  = 2;

  // Darkest-pixel tracker start: above every possible R+G+B
  localparam logic [SUM_W-1:0] LOW_SUM_START = SUM_W'(256 * 3 + 1);

  // Report codes, emitted in this order at frame end
  localparam logic [KIND_W-1:0] KIND_MAX_PIXEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MIN_PIXEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHAN_MAX  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CHAN_MIN  = 2'd3;

endpackage

### rtl/image_min_max_statistics_top.sv
// ----------------------------------------------------------------------------
// image_min_max_statistics_top
// Per-frame pixel statistics: brightest and darkest pixel by R+G+B with
// their coordinates, plus per-channel minima and maxima, reported at frame end.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  pixel   | in        | in_valid / in_stall | red, green, blue
//  report  | out       | out_valid/out_stall | report_kind, coord_x, coord_y,
//          |           |                     | out_red, out_green, out_blue,
//          |           |                     | last_of_run
//  config  | in        | wr_en               | wr_index, wr_data
//
// One pixel is accepted per cycle unless in_stall; trackers update in the cycle
// of acceptance. The frame's last pixel copies the final statistics into a
// report buffer and clears the trackers, so the next frame streams in while
// four reports drain, one per cycle unless out_stall. The report buffer holds
// one frame: a frame end during the previous reports' drain stalls pixel input.
// Reset (rst, synchronous) clears position, trackers and the report state.
// ----------------------------------------------------------------------------
module image_min_max_statistics_top #(
  parameter int MAX_DIM = imms_pkg::DEFAULT_MAX_DIM
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          wr_en,
  input  logic [imms_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [imms_pkg::CFG_W-1:0]    wr_data,
  // pixel input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [imms_pkg::CHAN_W-1:0]   red,
  input  logic [imms_pkg::CHAN_W-1:0]   green,
  input  logic [imms_pkg::CHAN_W-1:0]   blue,
  // report output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [imms_pkg::KIND_W-1:0]   report_kind,
  output logic [imms_pkg::COORD_W-1:0]  coord_x,
  output logic [imms_pkg::COORD_W-1:0]  coord_y,
  output logic [imms_pkg::CHAN_W-1:0]   out_red,
  output logic [imms_pkg::CHAN_W-1:0]   out_green,
  output logic [imms_pkg::CHAN_W-1:0]   out_blue,
  output logic                          last_of_run
);

  localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CMP_W = (DIM_W + 1 > imms_pkg::CFG_W) ? DIM_W + 1 : imms_pkg::CFG_W;
  localparam int CW    = imms_pkg::CHAN_W;
  localparam int SW    = imms_pkg::SUM_W;
  localparam int KW    = imms_pkg::KIND_W;
  localparam int COLW  = imms_pkg::COLOR_W;

  // Configuration registers
  logic [imms_pkg::CFG_W-1:0] frame_width;
  logic [imms_pkg::CFG_W-1:0] frame_height;

  // Frame position and trackers
  logic [DIM_W-1:0] column;
  logic [DIM_W-1:0] row;
  logic             frame_started;
  logic [SW-1:0]    low_sum;
  logic [DIM_W-1:0] low_x;
  logic [DIM_W-1:0] low_y;
  logic [COLW-1:0]  low_colour;
  logic [SW-1:0]    high_sum;
  logic [DIM_W-1:0] high_x;
  logic [DIM_W-1:0] high_y;
  logic [COLW-1:0]  high_colour;
  logic [COLW-1:0]  channel_minima;
  logic [COLW-1:0]  channel_maxima;

  // Next tracker values for the current pixel
  logic [SW-1:0]    low_sum_next;
  logic [DIM_W-1:0] low_x_next;
  logic [DIM_W-1:0] low_y_next;
  logic [COLW-1:0]  low_colour_next;
  logic [SW-1:0]    high_sum_next;
  logic [DIM_W-1:0] high_x_next;
  logic [DIM_W-1:0] high_y_next;
  logic [COLW-1:0]  high_colour_next;
  logic [COLW-1:0]  channel_minima_next;
  logic [COLW-1:0]  channel_maxima_next;

  // Report buffer
  logic             rep_busy;
  logic [KW-1:0]    rep_idx;
  logic [DIM_W-1:0] rep_high_x;
  logic [DIM_W-1:0] rep_high_y;
  logic [COLW-1:0]  rep_high_colour;
  logic [DIM_W-1:0] rep_low_x;
  logic [DIM_W-1:0] rep_low_y;
  logic [COLW-1:0]  rep_low_colour;
  logic [COLW-1:0]  rep_maxima;
  logic [COLW-1:0]  rep_minima;

  // Combinational helpers
  logic [CMP_W-1:0] width_clamped;
  logic [CMP_W-1:0] height_clamped;
  logic             last_col;
  logic             last_row;
  logic             frame_end;
  logic [SW-1:0]    pixel_sum;
  logic [COLW-1:0]  pixel_colour;
  logic             take_low;
  logic             take_high;
  logic             in_take;
  logic             out_take;
  logic             rep_done;
  logic [COLW-1:0]  rep_colour;

  // Write configuration registers; other indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= imms_pkg::FRAME_WIDTH_RESET;
      frame_height <= imms_pkg::FRAME_HEIGHT_RESET;
    end else if (wr_en) begin
      if (wr_index == imms_pkg::REG_FRAME_WIDTH) begin
        frame_width <= wr_data;
      end
      if (wr_index == imms_pkg::REG_FRAME_HEIGHT) begin
        frame_height <= wr_data;
      end
    end
  end

  // Clamp frame size to 1..MAX_DIM and find the last column and row
  always_comb begin
    width_clamped  = CMP_W'(frame_width);
    height_clamped = CMP_W'(frame_height);
    if (width_clamped == '0) begin
      width_clamped = CMP_W'(1);
    end else if (width_clamped > CMP_W'(MAX_DIM)) begin
      width_clamped = CMP_W'(MAX_DIM);
    end
    if (height_clamped == '0) begin
      height_clamped = CMP_W'(1);
    end else if (height_clamped > CMP_W'(MAX_DIM)) begin
      height_clamped = CMP_W'(MAX_DIM);
    end
  end

  assign last_col  = CMP_W'(column) >= (width_clamped - CMP_W'(1));
  assign last_row  = CMP_W'(row) >= (height_clamped - CMP_W'(1));
  assign frame_end = last_col && last_row;

  // Handshakes: hold a frame end while the report buffer is still draining
  assign out_valid = rep_busy;
  assign out_take  = out_valid && !out_stall;
  assign rep_done  = out_take && (rep_idx == imms_pkg::KIND_CHAN_MIN);
  assign in_stall  = rep_busy && frame_end && !rep_done;
  assign in_take   = in_valid && !in_stall;

  // Evaluate the current pixel against the trackers
  assign pixel_sum    = SW'(red) + SW'(green) + SW'(blue);
  assign pixel_colour = {red, green, blue};
  assign take_low     = pixel_sum < low_sum;
  assign take_high    = !frame_started || (pixel_sum > high_sum);

  always_comb begin
    low_sum_next     = take_low ? pixel_sum : low_sum;
    low_x_next       = take_low ? column : low_x;
    low_y_next       = take_low ? row : low_y;
    low_colour_next  = take_low ? pixel_colour : low_colour;
    high_sum_next    = take_high ? pixel_sum : high_sum;
    high_x_next      = take_high ? column : high_x;
    high_y_next      = take_high ? row : high_y;
    high_colour_next = take_high ? pixel_colour : high_colour;

    channel_minima_next[3*CW-1:2*CW] =
      (red < channel_minima[3*CW-1:2*CW]) ? red : channel_minima[3*CW-1:2*CW];
    channel_minima_next[2*CW-1:CW] =
      (green < channel_minima[2*CW-1:CW]) ? green : channel_minima[2*CW-1:CW];
    channel_minima_next[CW-1:0] =
      (blue < channel_minima[CW-1:0]) ? blue : channel_minima[CW-1:0];

    channel_maxima_next[3*CW-1:2*CW] =
      (red > channel_maxima[3*CW-1:2*CW]) ? red : channel_maxima[3*CW-1:2*CW];
    channel_maxima_next[2*CW-1:CW] =
      (green > channel_maxima[2*CW-1:CW]) ? green : channel_maxima[2*CW-1:CW];
    channel_maxima_next[CW-1:0] =
      (blue > channel_maxima[CW-1:0]) ? blue : channel_maxima[CW-1:0];
  end

  // Advance position and trackers; clear them after the frame's last pixel
  always_ff @(posedge clk) begin
    if (rst || (in_take && frame_end)) begin
      column         <= '0;
      row            <= '0;
      frame_started  <= 1'b0;
      low_sum        <= imms_pkg::LOW_SUM_START;
      low_x          <= '0;
      low_y          <= '0;
      low_colour     <= '0;
      high_sum       <= '0;
      high_x         <= '0;
      high_y         <= '0;
      high_colour    <= '0;
      channel_minima <= '1;
      channel_maxima <= '0;
    end else if (in_take) begin
      if (last_col) begin
        column <= '0;
        row    <= DIM_W'(row + 1'b1);
      end else begin
        column <= DIM_W'(column + 1'b1);
      end
      frame_started  <= 1'b1;
      low_sum        <= low_sum_next;
      low_x          <= low_x_next;
      low_y          <= low_y_next;
      low_colour     <= low_colour_next;
      high_sum       <= high_sum_next;
      high_x         <= high_x_next;
      high_y         <= high_y_next;
      high_colour    <= high_colour_next;
      channel_minima <= channel_minima_next;
      channel_maxima <= channel_maxima_next;
    end
  end

  // Capture final statistics into the report buffer at frame end
  always_ff @(posedge clk) begin
    if (in_take && frame_end) begin
      rep_high_x      <= high_x_next;
      rep_high_y      <= high_y_next;
      rep_high_colour <= high_colour_next;
      rep_low_x       <= low_x_next;
      rep_low_y       <= low_y_next;
      rep_low_colour  <= low_colour_next;
      rep_maxima      <= channel_maxima_next;
      rep_minima      <= channel_minima_next;
    end
  end

  // Step through the four reports
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_busy <= 1'b0;
      rep_idx  <= imms_pkg::KIND_MAX_PIXEL;
    end else if (in_take && frame_end) begin
      rep_busy <= 1'b1;
      rep_idx  <= imms_pkg::KIND_MAX_PIXEL;
    end else if (out_take) begin
      if (rep_idx == imms_pkg::KIND_CHAN_MIN) begin
        rep_busy <= 1'b0;
      end else begin
        rep_idx <= KW'(rep_idx + 1'b1);
      end
    end
  end

  // Select the report fields
  always_comb begin
    coord_x    = '0;
    coord_y    = '0;
    rep_colour = rep_minima;
    unique case (rep_idx)
      imms_pkg::KIND_MAX_PIXEL: begin
        coord_x    = imms_pkg::COORD_W'(rep_high_x);
        coord_y    = imms_pkg::COORD_W'(rep_high_y);
        rep_colour = rep_high_colour;
      end
      imms_pkg::KIND_MIN_PIXEL: begin
        coord_x    = imms_pkg::COORD_W'(rep_low_x);
        coord_y    = imms_pkg::COORD_W'(rep_low_y);
        rep_colour = rep_low_colour;
      end
      imms_pkg::KIND_CHAN_MAX: begin
        rep_colour = rep_maxima;
      end
      imms_pkg::KIND_CHAN_MIN: begin
        rep_colour = rep_minima;
      end
      default: begin
        rep_colour = rep_minima;
      end
    endcase
  end

  assign report_kind = rep_idx;
  assign out_red     = rep_colour[3*CW-1:2*CW];
  assign out_green   = rep_colour[2*CW-1:CW];
  assign out_blue    = rep_colour[CW-1:0];
  assign last_of_run = (rep_idx == imms_pkg::KIND_CHAN_MIN);

  // A frame end starts the report sequence at the max-pixel report
  a_frame_end_starts_reports: assert property (@(posedge clk) disable iff (rst)
    (in_take && frame_end) |=> (out_valid && report_kind == imms_pkg::KIND_MAX_PIXEL))
    else $error("frame end did not start a report sequence");

  // A frame end clears position and trackers
  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_take && frame_end) |=> (column == '0 && row == '0 && !frame_started))
    else $error("trackers not cleared after frame end");

  // A stalled report keeps its place in the sequence
  a_report_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(rep_idx)))
    else $error("report advanced while stalled");

  // The report buffer is never overwritten while reports remain
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_take && frame_end && rep_busy) |-> rep_done)
    else $error("report buffer overwritten before drained");

endmodule
